[rtl/core/sha256_block_compress_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the SHA-256 block compression engine
// Clocked on clk_i and disabled during reset (rst_ni low).
// ---------------------------------------------------------------------------
`ifndef SHA256_BLOCK_COMPRESS_TOP_ASSERT_SVH
`define SHA256_BLOCK_COMPRESS_TOP_ASSERT_SVH

// Same-cycle implication.
`define SHA256BC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sha256bc assertion failed");

// Next-cycle implication.
`define SHA256BC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sha256bc assertion failed");

`endif

[rtl/core/sha256bc_pkg.sv]
// ---------------------------------------------------------------------------
// sha256bc_pkg
// Types, constants and round functions of the SHA-256 compression engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha256bc_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned NumWords  = 16;
  localparam int unsigned NumVars   = 8;
  localparam int unsigned NumRounds = 64;

  typedef logic [WordW-1:0] word_t;

  // Input item: one message word plus the message start flag
  typedef struct packed {
    logic [31:0] message_word;
    logic        start_message;
  } sha256bc_in_t;

  // Output item: one digest word with its position
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } sha256bc_out_t;

  // Controls from the sequencer to the schedule window and round unit
  typedef struct packed {
    logic shift_in;    // accepted message word enters the window
    logic expand;      // window advances by one expanded word
    logic vars_load;   // working variables take the chaining value
    logic round_step;  // one compression round
  } sha256bc_ctrl_t;

  // Standard initial hash, index 0 is H0
  localparam word_t [NumVars-1:0] InitHash = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t rotr(input word_t v, input int unsigned n);
    rotr = (v >> n) | (v << (WordW - n));
  endfunction

  function automatic word_t big_sigma0(input word_t v);
    big_sigma0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t v);
    big_sigma1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t v);
    small_sigma0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t v);
    small_sigma1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

  // Round constants
  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    round_k = k;
  endfunction

endpackage

[rtl/core/sha256bc_sched.sv]
// ---------------------------------------------------------------------------
// sha256bc_sched
// Sixteen-word message schedule window. Message words shift in at the top;
// during the rounds the window advances one expanded word per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256bc_sched
  import sha256bc_pkg::*;
(
  input  logic           clk_i,
  input  sha256bc_ctrl_t ctrl_i,
  input  word_t          word_i,
  output word_t          wt_o
);

  word_t w_q [NumWords];
  word_t w_new;

  // W[t+16] from the current window, W[t] sits at the bottom
  assign w_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];

  // Shift the window down by one; the top takes a message or expanded word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_in || ctrl_i.expand) begin
      for (int i = 0; i < NumWords - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[NumWords-1] <= ctrl_i.shift_in ? word_i : w_new;
    end
  end

  assign wt_o = w_q[0];

endmodule

[rtl/core/sha256bc_round.sv]
// ---------------------------------------------------------------------------
// sha256bc_round
// Shared round unit: holds the working variables a..h and applies one
// compression round per step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256bc_round
  import sha256bc_pkg::*;
(
  input  logic                clk_i,
  input  sha256bc_ctrl_t      ctrl_i,
  input  word_t [NumVars-1:0] init_i,
  input  word_t               wt_i,
  input  word_t               kt_i,
  output word_t [NumVars-1:0] vars_o
);

  word_t [NumVars-1:0] vars_q;
  word_t [NumVars-1:0] vars_d;
  word_t               t1;
  word_t               t2;
  word_t               ch;
  word_t               maj;

  // Index 0 is a, index 7 is h
  assign ch  = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
  assign maj = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
  assign t1  = vars_q[7] + big_sigma1(vars_q[4]) + ch + kt_i + wt_i;
  assign t2  = big_sigma0(vars_q[0]) + maj;

  always_comb begin
    vars_d    = vars_q;
    vars_d[7] = vars_q[6];
    vars_d[6] = vars_q[5];
    vars_d[5] = vars_q[4];
    vars_d[4] = vars_q[3] + t1;
    vars_d[3] = vars_q[2];
    vars_d[2] = vars_q[1];
    vars_d[1] = vars_q[0];
    vars_d[0] = t1 + t2;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.vars_load) begin
      vars_q <= init_i;
    end else if (ctrl_i.round_step) begin
      vars_q <= vars_d;
    end
  end

  assign vars_o = vars_q;

endmodule

[rtl/core/sha256_block_compress_top.sv]
// ---------------------------------------------------------------------------
// sha256_block_compress_top
// SHA-256 block compression engine: 16 words in, 8 digest words out.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes one 32-bit
//   big-endian word of an already padded message per item. Set
//   start_message on the first word of a message to reload the initial hash.
//   Without it, blocks keep chaining on the current value.
//   After the sixteenth word of a block the engine stalls its input, runs
//   64 rounds (one per cycle in the shared round unit), adds the working
//   variables into the chaining value in ST_FINAL, then presents the eight
//   digest words on the output channel (out_valid_o / out_stall_i /
//   out_item_o), index 0 first, digest_last on index 7.
//   The round loop dominates the time that a block takes.
//   A stalled output holds its item; the input stays stalled until the
//   eighth word is taken.
//   Reset loads the initial hash and clears the word and round counters.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_block_compress_top
  import sha256bc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sha256bc_in_t  in_item_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sha256bc_out_t out_item_o
);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_FINAL = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [3:0]          word_cnt_q, word_cnt_d;
  logic [5:0]          round_cnt_q, round_cnt_d;
  logic [2:0]          out_idx_q, out_idx_d;
  word_t [NumVars-1:0] chain_q, chain_d;
  word_t [NumVars-1:0] vars;
  word_t               wt;
  word_t               kt;
  sha256bc_ctrl_t      ctrl;
  logic                in_acc;
  logic                out_acc;
  logic                block_done;

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = (state_q == ST_OUT);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;

  // Sixteenth word of a block; a start word is always word 0
  assign block_done = in_acc && !in_item_i.start_message && (word_cnt_q == 4'd15);

  assign kt = round_k(round_cnt_q);

  always_comb begin
    ctrl            = '0;
    ctrl.shift_in   = in_acc;
    ctrl.expand     = (state_q == ST_ROUND);
    ctrl.vars_load  = block_done;
    ctrl.round_step = (state_q == ST_ROUND);
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    word_cnt_d  = word_cnt_q;
    round_cnt_d = round_cnt_q;
    out_idx_d   = out_idx_q;
    chain_d     = chain_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (in_item_i.start_message) begin
            chain_d    = InitHash;
            word_cnt_d = 4'd1;
          end else begin
            word_cnt_d = word_cnt_q + 4'd1;
          end
          if (block_done) begin
            state_d = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        round_cnt_d = round_cnt_q + 6'd1;
        if (round_cnt_q == 6'(NumRounds - 1)) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        for (int i = 0; i < NumVars; i++) begin
          chain_d[i] = chain_q[i] + vars[i];
        end
        out_idx_d = '0;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc) begin
          out_idx_d = out_idx_q + 3'd1;
          if (out_idx_q == 3'(NumVars - 1)) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      word_cnt_q  <= '0;
      round_cnt_q <= '0;
      out_idx_q   <= '0;
      chain_q     <= InitHash;
    end else begin
      state_q     <= state_d;
      word_cnt_q  <= word_cnt_d;
      round_cnt_q <= round_cnt_d;
      out_idx_q   <= out_idx_d;
      chain_q     <= chain_d;
    end
  end

  sha256bc_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .word_i (in_item_i.message_word),
    .wt_o   (wt)
  );

  sha256bc_round u_round (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .init_i (chain_q),
    .wt_i   (wt),
    .kt_i   (kt),
    .vars_o (vars)
  );

  // Digest output straight from the chaining registers
  always_comb begin
    out_item_o              = '0;
    out_item_o.digest_word  = chain_q[out_idx_q];
    out_item_o.digest_index = out_idx_q;
    out_item_o.digest_last  = (out_idx_q == 3'(NumVars - 1));
  end

`include "sha256_block_compress_top_assert.svh"

  // Round counter only moves inside the round loop
  `SHA256BC_ASSERT_NOW(a_round_cnt_idle, (state_q != ST_ROUND), (round_cnt_q == 6'd0))
  // Finalization hands over to the first digest word
  `SHA256BC_ASSERT_NEXT(a_final_to_out, (state_q == ST_FINAL), (out_valid_o && out_idx_q == 3'd0))
  // Taking the last digest word reopens the input
  `SHA256BC_ASSERT_NEXT(a_last_reopens, (out_acc && out_item_o.digest_last), (!in_stall_o && !out_valid_o))

endmodule
